>>> design/irqva_pkg.sv
// ----------------------------------------------------------------------------
// irqva_pkg
// Shared types and constants of the irq vector slot allocator.
// ----------------------------------------------------------------------------
package irqva_pkg;

  localparam int unsigned IRQ_W  = 9;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned IDX_W  = 8;

  localparam logic [SLOT_W-1:0] NO_SLOT = '1;

  localparam logic [IRQ_W-1:0] MSI_BASE_RST    = 9'd128;
  localparam logic [IRQ_W-1:0] VECTOR_BASE_RST = 9'd64;
  localparam logic [IRQ_W-1:0] MSI_COUNT_RST   = 9'd192;

  // MSI bitmap is searched in groups of this size
  localparam int unsigned MSI_GROUP   = 16;
  localparam int unsigned MSI_GROUP_W = 4;

  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned RSP_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_MSI_CREATE     = 2'd0,
    MODE_MSI_DESTROY    = 2'd1,
    MODE_DIRECT_CREATE  = 2'd2,
    MODE_DIRECT_DESTROY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_NOT_MAPPED = 2'd2,
    ST_RANGE      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MSI_BASE    = 2'd0,
    REG_VECTOR_BASE = 2'd1,
    REG_MSI_COUNT   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    mode_e            mode;
    logic [IRQ_W-1:0] irq_number;
    logic             with_ipi;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [IRQ_W-1:0]  irq_out;
    logic [SLOT_W-1:0] direct_slot;
    logic              direct_done;
  } rsp_t;

  typedef struct packed {
    logic [IRQ_W-1:0] msi_base;
    logic [IRQ_W-1:0] vector_base;
    logic [IRQ_W-1:0] msi_active;  // msi_count clamped to the bitmap size
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    mode_e            mode;
    logic [IRQ_W-1:0] irq;
    logic             ipi;
    logic             range_err;
    logic [IDX_W-1:0] vec;
    logic [IDX_W-1:0] msi_slot;
  } cmd_t;

endpackage

>>> design/irqva_ram.sv
// ----------------------------------------------------------------------------
// irqva_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module irqva_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/irqva_fifo.sv
// ----------------------------------------------------------------------------
// irqva_fifo
// Small register FIFO used between front and back and on the result side.
// ----------------------------------------------------------------------------
module irqva_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("fifo count beyond depth");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push && cnt_q == CntW'(1)) |=> empty_o)
    else $error("fifo not empty after last entry popped");

endmodule

>>> design/irqva_front.sv
// ----------------------------------------------------------------------------
// irqva_front
// Accepts requests and classifies them: io vector index, MSI slot of a
// destroy and the range checks that do not depend on allocator state.
// ----------------------------------------------------------------------------
module irqva_front #(
  parameter int unsigned IO_VECTORS = 256
) (
  input  irqva_pkg::cfg_t cfg_i,
  input  logic            push_i,
  input  irqva_pkg::req_t req_i,
  input  logic            cmd_full_i,
  output logic            cmd_push_o,
  output irqva_pkg::cmd_t cmd_o
);

  logic [irqva_pkg::IRQ_W-1:0] vec_diff;
  logic [irqva_pkg::IRQ_W-1:0] msi_diff;
  logic                        vec_ok;
  logic                        msi_ok;

  assign cmd_push_o = push_i && !cmd_full_i;

  always_comb begin
    vec_diff = req_i.irq_number - cfg_i.vector_base;
    msi_diff = req_i.irq_number - cfg_i.msi_base;
    vec_ok   = (req_i.irq_number >= cfg_i.vector_base) &&
               ({1'b0, vec_diff} < 10'(IO_VECTORS));
    msi_ok   = (req_i.irq_number >= cfg_i.msi_base) &&
               (msi_diff < cfg_i.msi_active);

    cmd_o.mode      = req_i.mode;
    cmd_o.irq       = req_i.irq_number;
    cmd_o.ipi       = req_i.with_ipi;
    cmd_o.vec       = vec_diff[irqva_pkg::IDX_W-1:0];
    cmd_o.msi_slot  = msi_diff[irqva_pkg::IDX_W-1:0];
    cmd_o.range_err = 1'b0;
    case (req_i.mode)
      irqva_pkg::MODE_MSI_CREATE: begin
        // irq comes from the bitmap search; checked in the back end
        cmd_o.range_err = 1'b0;
      end
      irqva_pkg::MODE_MSI_DESTROY: begin
        cmd_o.range_err = !msi_ok || (req_i.with_ipi && !vec_ok);
      end
      irqva_pkg::MODE_DIRECT_CREATE,
      irqva_pkg::MODE_DIRECT_DESTROY: begin
        cmd_o.range_err = !vec_ok;
      end
      default: begin
        cmd_o.range_err = 1'b1;
      end
    endcase
  end

endmodule

>>> design/irqva_back.sv
// ----------------------------------------------------------------------------
// irqva_back
// Executes classified commands: MSI bitmap search, direct-route slot
// allocation and the vector-to-slot map (RAM plus per-entry valid bits).
// ----------------------------------------------------------------------------
module irqva_back #(
  parameter int unsigned DIRECT_SLOTS = 26,
  parameter int unsigned MSI_SLOTS    = 256,
  parameter int unsigned IO_VECTORS   = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  irqva_pkg::cfg_t cfg_i,
  input  logic            cmd_empty_i,
  input  irqva_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  logic            rsp_full_i,
  output logic            rsp_push_o,
  output irqva_pkg::rsp_t rsp_o
);

  localparam int unsigned VecW    = (IO_VECTORS > 1) ? $clog2(IO_VECTORS) : 1;
  localparam int unsigned MsiW    = (MSI_SLOTS > 1) ? $clog2(MSI_SLOTS) : 1;
  localparam int unsigned NumGrp  = (MSI_SLOTS + irqva_pkg::MSI_GROUP - 1) /
                                    irqva_pkg::MSI_GROUP;
  localparam int unsigned PadBits = NumGrp * irqva_pkg::MSI_GROUP;

  irqva_pkg::back_state_e state_q, state_d;
  irqva_pkg::cmd_t        cmd_q;

  logic [MSI_SLOTS-1:0]    msi_used_q;
  logic [DIRECT_SLOTS-1:0] direct_used_q, direct_used_d;
  logic [IO_VECTORS-1:0]   vmap_valid_q;

  // first-level search results, registered per group
  logic [PadBits-1:0]                 msi_free_pad;
  logic [NumGrp-1:0]                  grp_any_d, grp_any_q;
  logic [irqva_pkg::MSI_GROUP_W-1:0]  grp_idx_d [NumGrp];
  logic [irqva_pkg::MSI_GROUP_W-1:0]  grp_idx_q [NumGrp];

  logic                         msi_found;
  logic [irqva_pkg::IRQ_W-1:0]  msi_slot;
  logic                         dir_found;
  logic [irqva_pkg::SLOT_W-1:0] dir_free;

  logic [irqva_pkg::IRQ_W:0]    alloc_irq;
  logic [irqva_pkg::IRQ_W-1:0]  alloc_vdiff;
  logic                         alloc_vec_ok;

  logic                         mapped;
  logic                         msi_wr, msi_val;
  logic [MsiW-1:0]              msi_idx;
  logic                         vmap_wr, vmap_val;
  logic [VecW-1:0]              vmap_idx;

  logic                         ram_we;
  logic [irqva_pkg::SLOT_W-1:0] ram_rdata;

  irqva_ram #(
    .WIDTH (irqva_pkg::SLOT_W),
    .DEPTH (IO_VECTORS)
  ) u_vmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (vmap_idx),
    .wdata_i (dir_free),
    .raddr_i (cmd_i.vec[VecW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign cmd_pop_o  = (state_q == irqva_pkg::BK_IDLE) && !cmd_empty_i && !rsp_full_i;
  assign rsp_push_o = (state_q == irqva_pkg::BK_EXEC);

  // Per-group free search over the active part of the MSI bitmap
  always_comb begin
    for (int i = 0; i < PadBits; i++) begin
      msi_free_pad[i] = 1'b0;
      if (i < MSI_SLOTS) begin
        msi_free_pad[i] = !msi_used_q[i] && (10'(i) < {1'b0, cfg_i.msi_active});
      end
    end
    for (int g = 0; g < NumGrp; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int b = irqva_pkg::MSI_GROUP - 1; b >= 0; b--) begin
        if (msi_free_pad[g * irqva_pkg::MSI_GROUP + b]) begin
          grp_any_d[g] = 1'b1;
          grp_idx_d[g] = irqva_pkg::MSI_GROUP_W'(b);
        end
      end
    end
  end

  // Second level: lowest group with a free slot; lowest free direct slot
  always_comb begin
    msi_found = 1'b0;
    msi_slot  = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        msi_found = 1'b1;
        msi_slot  = irqva_pkg::IRQ_W'(g * irqva_pkg::MSI_GROUP) +
                    irqva_pkg::IRQ_W'(grp_idx_q[g]);
      end
    end
    dir_found = 1'b0;
    dir_free  = irqva_pkg::NO_SLOT;
    for (int d = DIRECT_SLOTS - 1; d >= 0; d--) begin
      if (!direct_used_q[d]) begin
        dir_found = 1'b1;
        dir_free  = irqva_pkg::SLOT_W'(d);
      end
    end
  end

  always_comb begin
    alloc_irq    = {1'b0, cfg_i.msi_base} + {1'b0, msi_slot};
    alloc_vdiff  = alloc_irq[irqva_pkg::IRQ_W-1:0] - cfg_i.vector_base;
    alloc_vec_ok = (alloc_irq[irqva_pkg::IRQ_W-1:0] >= cfg_i.vector_base) &&
                   ({1'b0, alloc_vdiff} < 10'(IO_VECTORS));
    mapped       = vmap_valid_q[cmd_q.vec[VecW-1:0]] &&
                   (ram_rdata < irqva_pkg::SLOT_W'(DIRECT_SLOTS));
  end

  always_comb begin
    state_d       = state_q;
    direct_used_d = direct_used_q;
    msi_wr        = 1'b0;
    msi_val       = 1'b0;
    msi_idx       = cmd_q.msi_slot[MsiW-1:0];
    vmap_wr       = 1'b0;
    vmap_val      = 1'b0;
    vmap_idx      = cmd_q.vec[VecW-1:0];
    ram_we        = 1'b0;

    rsp_o.status      = irqva_pkg::ST_OK;
    rsp_o.irq_out     = cmd_q.irq;
    rsp_o.direct_slot = irqva_pkg::NO_SLOT;
    rsp_o.direct_done = 1'b0;

    case (state_q)
      irqva_pkg::BK_IDLE: begin
        if (cmd_pop_o) begin
          state_d = irqva_pkg::BK_EXEC;
        end
      end
      irqva_pkg::BK_EXEC: begin
        state_d = irqva_pkg::BK_IDLE;
        case (cmd_q.mode)
          irqva_pkg::MODE_MSI_CREATE: begin
            rsp_o.irq_out = '0;
            msi_idx       = msi_slot[MsiW-1:0];
            vmap_idx      = alloc_vdiff[VecW-1:0];
            if (!msi_found) begin
              rsp_o.status = irqva_pkg::ST_NO_SPACE;
            end else if (alloc_irq[irqva_pkg::IRQ_W] || (cmd_q.ipi && !alloc_vec_ok)) begin
              rsp_o.status = irqva_pkg::ST_RANGE;
            end else begin
              msi_wr        = 1'b1;
              msi_val       = 1'b1;
              rsp_o.irq_out = alloc_irq[irqva_pkg::IRQ_W-1:0];
              // a full direct pool still leaves the MSI allocated
              if (cmd_q.ipi && dir_found) begin
                direct_used_d     = direct_used_q | (DIRECT_SLOTS'(1) << dir_free);
                vmap_wr           = 1'b1;
                vmap_val          = 1'b1;
                ram_we            = 1'b1;
                rsp_o.direct_slot = dir_free;
                rsp_o.direct_done = 1'b1;
              end
            end
          end
          irqva_pkg::MODE_DIRECT_CREATE: begin
            if (cmd_q.range_err) begin
              rsp_o.status = irqva_pkg::ST_RANGE;
            end else if (!dir_found) begin
              rsp_o.status = irqva_pkg::ST_NO_SPACE;
            end else begin
              direct_used_d     = direct_used_q | (DIRECT_SLOTS'(1) << dir_free);
              vmap_wr           = 1'b1;
              vmap_val          = 1'b1;
              ram_we            = 1'b1;
              rsp_o.direct_slot = dir_free;
              rsp_o.direct_done = 1'b1;
            end
          end
          irqva_pkg::MODE_MSI_DESTROY,
          irqva_pkg::MODE_DIRECT_DESTROY: begin
            if (cmd_q.range_err) begin
              rsp_o.status = irqva_pkg::ST_RANGE;
            end else begin
              if (cmd_q.mode == irqva_pkg::MODE_DIRECT_DESTROY || cmd_q.ipi) begin
                if (!mapped) begin
                  rsp_o.status = irqva_pkg::ST_NOT_MAPPED;
                end else begin
                  direct_used_d     = direct_used_q & ~(DIRECT_SLOTS'(1) << ram_rdata);
                  vmap_wr           = 1'b1;  // clearing valid reads back as unmapped
                  rsp_o.direct_slot = ram_rdata;
                  rsp_o.direct_done = 1'b1;
                end
              end
              if (cmd_q.mode == irqva_pkg::MODE_MSI_DESTROY) begin
                msi_wr = 1'b1;
              end
            end
          end
          default: begin
            rsp_o.status = irqva_pkg::ST_RANGE;
          end
        endcase
      end
      default: begin
        state_d = irqva_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= irqva_pkg::BK_IDLE;
      msi_used_q    <= '0;
      direct_used_q <= '0;
      vmap_valid_q  <= '0;
    end else begin
      state_q       <= state_d;
      direct_used_q <= direct_used_d;
      if (msi_wr) begin
        msi_used_q[msi_idx] <= msi_val;
      end
      if (vmap_wr) begin
        vmap_valid_q[vmap_idx] <= vmap_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q     <= cmd_i;
      grp_any_q <= grp_any_d;
      grp_idx_q <= grp_idx_d;
    end
  end

  a_pop_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> rsp_push_o)
    else $error("command popped without a result next cycle");

  a_result_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push_o |-> !rsp_full_i)
    else $error("result pushed into a full queue");

  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_push_o && rsp_o.direct_done) |->
      (rsp_o.status == irqva_pkg::ST_OK &&
       rsp_o.direct_slot < irqva_pkg::SLOT_W'(DIRECT_SLOTS)))
    else $error("direct slot reported on a failed or invalid slot");

endmodule

>>> design/irq_vector_slot_allocator.sv
// The back end latches each request from the command queue and executes it in its
//   EXEC state; it takes no new one until it has pushed the result, owing to its
//   read-then-write of the vector map RAM and the two-level MSI bitmap search.
// Reset: clears all slot bitmaps and map valid bits at once (no clearing pass),
//   loads msi_base 128, vector_base 64, msi_count 192; queues come up empty.
// ----------------------------------------------------------------------------
// irq_vector_slot_allocator
// First-fit allocator of MSI irq numbers and direct-route slots, with a
// front classifier, a command queue, an execution back end and a result queue.
// ----------------------------------------------------------------------------
module irq_vector_slot_allocator #(
  parameter int unsigned DIRECT_SLOTS = 26,
  parameter int unsigned MSI_SLOTS    = 256,
  parameter int unsigned IO_VECTORS   = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  irqva_pkg::req_t             req_i,
  output logic                        empty,
  input  logic                        pop,
  output irqva_pkg::rsp_t             rsp_o,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index_i,
  input  logic [irqva_pkg::IRQ_W-1:0] cfg_data_i
);

  logic [irqva_pkg::IRQ_W-1:0] msi_base_q, vector_base_q, msi_count_q;
  irqva_pkg::cfg_t             cfg;

  logic                          cmd_push, cmd_full, cmd_pop, cmd_empty;
  irqva_pkg::cmd_t               cmd_in, cmd_head;
  logic [$bits(irqva_pkg::cmd_t)-1:0] cmd_rdata;

  logic                          rsp_push, rsp_full;
  irqva_pkg::rsp_t               rsp_in;
  logic [$bits(irqva_pkg::rsp_t)-1:0] rsp_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msi_base_q    <= irqva_pkg::MSI_BASE_RST;
      vector_base_q <= irqva_pkg::VECTOR_BASE_RST;
      msi_count_q   <= irqva_pkg::MSI_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (irqva_pkg::cfg_reg_e'(cfg_index_i))
        irqva_pkg::REG_MSI_BASE:    msi_base_q    <= cfg_data_i;
        irqva_pkg::REG_VECTOR_BASE: vector_base_q <= cfg_data_i;
        irqva_pkg::REG_MSI_COUNT:   msi_count_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.msi_base    = msi_base_q;
    cfg.vector_base = vector_base_q;
    cfg.msi_active  = ({1'b0, msi_count_q} > 10'(MSI_SLOTS)) ?
                      irqva_pkg::IRQ_W'(MSI_SLOTS) : msi_count_q;
  end

  irqva_front #(
    .IO_VECTORS (IO_VECTORS)
  ) u_front (
    .cfg_i      (cfg),
    .push_i     (push),
    .req_i      (req_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  assign full = cmd_full;

  irqva_fifo #(
    .WIDTH ($bits(irqva_pkg::cmd_t)),
    .DEPTH (irqva_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_head = irqva_pkg::cmd_t'(cmd_rdata);

  irqva_back #(
    .DIRECT_SLOTS (DIRECT_SLOTS),
    .MSI_SLOTS    (MSI_SLOTS),
    .IO_VECTORS   (IO_VECTORS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp_in)
  );

  irqva_fifo #(
    .WIDTH ($bits(irqva_pkg::rsp_t)),
    .DEPTH (irqva_pkg::RSP_QUEUE_DEPTH)
  ) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .wdata_i (rsp_in),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .rdata_o (rsp_rdata),
    .empty_o (empty)
  );

  assign rsp_o = irqva_pkg::rsp_t'(rsp_rdata);

endmodule
